// ----- rtl/lpe_pkg.sv -----
// Shared types, constants and fixed-point helpers for the Legendre polynomial evaluator.
`timescale 1ns / 1ps
`default_nettype none

package lpe_pkg;

  localparam int ORDER_W   = 6;
  localparam int XW        = 32;
  localparam int FRAC_BITS = 30;
  localparam int MAX_ORDER = 63;

  localparam int PROD_W  = 65;
  localparam int RND_W   = 33;
  localparam int DIFF_W  = 33;
  localparam int RECIP_W = 31;
  localparam int SUM_W   = 36;

  localparam logic signed [XW-1:0] FX_ONE  = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [XW-1:0] FX_MONE = -FX_ONE;
  localparam longint FX_ONE_L = 64'sd1 <<< FRAC_BITS;

  // round(2^FRAC_BITS / k); entry zero treated as k = 1
  localparam logic [RECIP_W-1:0] RECIP_TBL [2**ORDER_W] = '{
    RECIP_W'(FX_ONE_L),                  RECIP_W'(FX_ONE_L),
    RECIP_W'((FX_ONE_L + 2/2) / 2),      RECIP_W'((FX_ONE_L + 3/2) / 3),
    RECIP_W'((FX_ONE_L + 4/2) / 4),      RECIP_W'((FX_ONE_L + 5/2) / 5),
    RECIP_W'((FX_ONE_L + 6/2) / 6),      RECIP_W'((FX_ONE_L + 7/2) / 7),
    RECIP_W'((FX_ONE_L + 8/2) / 8),      RECIP_W'((FX_ONE_L + 9/2) / 9),
    RECIP_W'((FX_ONE_L + 10/2) / 10),    RECIP_W'((FX_ONE_L + 11/2) / 11),
    RECIP_W'((FX_ONE_L + 12/2) / 12),    RECIP_W'((FX_ONE_L + 13/2) / 13),
    RECIP_W'((FX_ONE_L + 14/2) / 14),    RECIP_W'((FX_ONE_L + 15/2) / 15),
    RECIP_W'((FX_ONE_L + 16/2) / 16),    RECIP_W'((FX_ONE_L + 17/2) / 17),
    RECIP_W'((FX_ONE_L + 18/2) / 18),    RECIP_W'((FX_ONE_L + 19/2) / 19),
    RECIP_W'((FX_ONE_L + 20/2) / 20),    RECIP_W'((FX_ONE_L + 21/2) / 21),
    RECIP_W'((FX_ONE_L + 22/2) / 22),    RECIP_W'((FX_ONE_L + 23/2) / 23),
    RECIP_W'((FX_ONE_L + 24/2) / 24),    RECIP_W'((FX_ONE_L + 25/2) / 25),
    RECIP_W'((FX_ONE_L + 26/2) / 26),    RECIP_W'((FX_ONE_L + 27/2) / 27),
    RECIP_W'((FX_ONE_L + 28/2) / 28),    RECIP_W'((FX_ONE_L + 29/2) / 29),
    RECIP_W'((FX_ONE_L + 30/2) / 30),    RECIP_W'((FX_ONE_L + 31/2) / 31),
    RECIP_W'((FX_ONE_L + 32/2) / 32),    RECIP_W'((FX_ONE_L + 33/2) / 33),
    RECIP_W'((FX_ONE_L + 34/2) / 34),    RECIP_W'((FX_ONE_L + 35/2) / 35),
    RECIP_W'((FX_ONE_L + 36/2) / 36),    RECIP_W'((FX_ONE_L + 37/2) / 37),
    RECIP_W'((FX_ONE_L + 38/2) / 38),    RECIP_W'((FX_ONE_L + 39/2) / 39),
    RECIP_W'((FX_ONE_L + 40/2) / 40),    RECIP_W'((FX_ONE_L + 41/2) / 41),
    RECIP_W'((FX_ONE_L + 42/2) / 42),    RECIP_W'((FX_ONE_L + 43/2) / 43),
    RECIP_W'((FX_ONE_L + 44/2) / 44),    RECIP_W'((FX_ONE_L + 45/2) / 45),
    RECIP_W'((FX_ONE_L + 46/2) / 46),    RECIP_W'((FX_ONE_L + 47/2) / 47),
    RECIP_W'((FX_ONE_L + 48/2) / 48),    RECIP_W'((FX_ONE_L + 49/2) / 49),
    RECIP_W'((FX_ONE_L + 50/2) / 50),    RECIP_W'((FX_ONE_L + 51/2) / 51),
    RECIP_W'((FX_ONE_L + 52/2) / 52),    RECIP_W'((FX_ONE_L + 53/2) / 53),
    RECIP_W'((FX_ONE_L + 54/2) / 54),    RECIP_W'((FX_ONE_L + 55/2) / 55),
    RECIP_W'((FX_ONE_L + 56/2) / 56),    RECIP_W'((FX_ONE_L + 57/2) / 57),
    RECIP_W'((FX_ONE_L + 58/2) / 58),    RECIP_W'((FX_ONE_L + 59/2) / 59),
    RECIP_W'((FX_ONE_L + 60/2) / 60),    RECIP_W'((FX_ONE_L + 61/2) / 61),
    RECIP_W'((FX_ONE_L + 62/2) / 62),    RECIP_W'((FX_ONE_L + 63/2) / 63)
  };

  typedef enum logic {
    MUL_X_CUR,
    MUL_D_RECIP
  } mul_sel_e;

  typedef struct packed {
    logic     load;
    mul_sel_e mul_sel;
    logic     prod_en;
    logic     rnd_en;
    logic     step;
  } ctl_cmd_t;

  typedef struct packed {
    logic init_last;
    logic last_step;
  } dp_sts_t;

  // round half away from zero, drop FRAC_BITS fraction bits
  function automatic logic signed [RND_W-1:0] fx_round(input logic signed [PROD_W-1:0] p);
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] r;
    mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
    r = (mag + (PROD_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    return p[PROD_W-1] ? -$signed(r[RND_W-1:0]) : $signed(r[RND_W-1:0]);
  endfunction

  function automatic logic signed [XW-1:0] fx_sat(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(FX_ONE);
    lo = SUM_W'(FX_MONE);
    if (v > hi) begin
      return FX_ONE;
    end else if (v < lo) begin
      return FX_MONE;
    end
    return v[XW-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/lpe_dp.sv -----
// Datapath: argument and degree registers, shared multiplier, rounding and recurrence update.
`timescale 1ns / 1ps
`default_nettype none

module lpe_dp (
  input  wire                                      clk_i,
  input  wire                                      rst_ni,
  input  wire lpe_pkg::ctl_cmd_t                   cmd_i,
  output lpe_pkg::dp_sts_t                         sts_o,
  input  wire logic        [lpe_pkg::ORDER_W-1:0]  order_i,
  input  wire logic signed [lpe_pkg::XW-1:0]       x_value_i,
  output logic signed      [lpe_pkg::XW-1:0]       poly_value_o
);
  import lpe_pkg::*;

  logic        [ORDER_W-1:0] n_sat;
  logic        [ORDER_W-1:0] n_q;
  logic        [ORDER_W-1:0] i_q;
  logic        [ORDER_W-1:0] k;
  logic        [ORDER_W:0]   i_inc;
  logic signed [XW-1:0]      x_sat;
  logic signed [XW-1:0]      x_q;
  logic signed [XW-1:0]      prev_q;
  logic signed [XW-1:0]      cur_q;
  logic signed [XW-1:0]      next_val;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [PROD_W-1:0]  prod_d;
  logic signed [RND_W-1:0]   t_q;
  logic signed [RND_W-1:0]   rnd_val;
  logic signed [DIFF_W-1:0]  d_q;
  logic signed [DIFF_W-1:0]  d_d;
  logic signed [RND_W-1:0]   op_a;
  logic signed [XW-1:0]      op_b;
  logic signed [SUM_W-1:0]   sum;

  always_comb begin
    n_sat = (int'(order_i) > MAX_ORDER) ? ORDER_W'(MAX_ORDER) : order_i;
    if (x_value_i > FX_ONE) begin
      x_sat = FX_ONE;
    end else if (x_value_i < FX_MONE) begin
      x_sat = FX_MONE;
    end else begin
      x_sat = x_value_i;
    end
  end

  assign i_inc   = {1'b0, i_q} + (ORDER_W+1)'(1);
  assign k       = i_inc[ORDER_W-1:0];
  assign rnd_val = fx_round(prod_q);

  assign op_a = (cmd_i.mul_sel == MUL_D_RECIP) ? d_q : RND_W'(x_q);
  assign op_b = (cmd_i.mul_sel == MUL_D_RECIP) ? $signed({1'b0, RECIP_TBL[k]}) : cur_q;
  assign prod_d = PROD_W'(op_a) * PROD_W'(op_b);

  assign d_d      = DIFF_W'(rnd_val) - DIFF_W'(prev_q);
  // next = 2t - P(i-1) - round(d * R(i+1))
  assign sum      = (SUM_W'(t_q) <<< 1) - SUM_W'(prev_q) - SUM_W'(rnd_val);
  assign next_val = fx_sat(sum);

  assign sts_o.init_last = (n_sat < ORDER_W'(2));
  assign sts_o.last_step = (i_inc == {1'b0, n_q});
  assign poly_value_o    = cur_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= '0;
      i_q <= '0;
    end else if (cmd_i.load) begin
      n_q <= n_sat;
      i_q <= ORDER_W'(1);
    end else if (cmd_i.step) begin
      i_q <= k;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q    <= x_sat;
      prev_q <= FX_ONE;
      cur_q  <= (n_sat == '0) ? FX_ONE : x_sat;
    end else if (cmd_i.step) begin
      prev_q <= cur_q;
      cur_q  <= next_val;
    end
    if (cmd_i.prod_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.rnd_en) begin
      t_q <= rnd_val;
      d_q <= d_d;
    end
  end

  a_cur_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |=> (cur_q <= FX_ONE && cur_q >= FX_MONE))
    else $error("recurrence value left unit range");

  a_step_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step && !cmd_i.load) |=> (i_q == $past(k)) && (i_q <= n_q))
    else $error("step counter passed the degree");

endmodule

`default_nettype wire

// ----- rtl/lpe_ctrl.sv -----
// Controller: sequences load, two multiply/round phases per recurrence step, and result strobe.
`timescale 1ns / 1ps
`default_nettype none

module lpe_ctrl (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      start,
  output logic                     busy,
  output logic                     done_o,
  output lpe_pkg::ctl_cmd_t        cmd_o,
  input  wire lpe_pkg::dp_sts_t    sts_i
);
  import lpe_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_RND1,
    ST_MUL2,
    ST_RND2,
    ST_OUT
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, busy_d;
  logic   done_q, done_d;
  logic   accept;

  assign accept = start && !busy_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE, ST_OUT: begin
        if (accept) begin
          state_d = sts_i.init_last ? ST_OUT : ST_MUL1;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_MUL1: state_d = ST_RND1;
      ST_RND1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_RND2;
      ST_RND2: state_d = sts_i.last_step ? ST_OUT : ST_MUL1;
      default: state_d = ST_IDLE;
    endcase
    busy_d = !(state_d inside {ST_IDLE, ST_OUT});
    done_d = (state_d == ST_OUT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
      done_q  <= done_d;
    end
  end

  always_comb begin
    cmd_o.load    = accept;
    cmd_o.mul_sel = (state_q == ST_MUL2) ? MUL_D_RECIP : MUL_X_CUR;
    cmd_o.prod_en = (state_q == ST_MUL1) || (state_q == ST_MUL2);
    cmd_o.rnd_en  = (state_q == ST_RND1);
    cmd_o.step    = (state_q == ST_RND2);
  end

  assign busy   = busy_q;
  assign done_o = done_q;

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy || done_o))
    else $error("accepted word produced neither work nor result");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_step_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RND2 && !sts_i.last_step) |=> (state_q == ST_MUL1))
    else $error("recurrence stopped early");

endmodule

`default_nettype wire

// ----- rtl/legendre_polynomial_eval_top.sv -----
// Top level of the Legendre polynomial evaluator P_n(x), Q2.30 fixed point.
// For n <= 1 the result is strobed in the cycle after accept. Otherwise each recurrence step
// makes two passes through the shared 33x32 multiplier, each followed by a rounding state,
// and the result is strobed after the last step.
// A new word may be accepted in the cycle the result is strobed; the receiver cannot stall.
// Reset (rst_ni low, asynchronous) returns the controller to idle with busy and done_o low.
`timescale 1ns / 1ps
`default_nettype none

module legendre_polynomial_eval_top (
  input  wire                                      clk_i,
  input  wire                                      rst_ni,
  input  wire                                      start,
  input  wire logic        [lpe_pkg::ORDER_W-1:0]  order_i,
  input  wire logic signed [lpe_pkg::XW-1:0]       x_value_i,
  output logic                                     busy,
  output logic                                     done_o,
  output logic signed      [lpe_pkg::XW-1:0]       poly_value_o
);
  import lpe_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  lpe_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd),
    .sts_i  (sts)
  );

  lpe_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .order_i      (order_i),
    .x_value_i    (x_value_i),
    .poly_value_o (poly_value_o)
  );

endmodule

`default_nettype wire
